// ----- sv/assert_macros.svh -----
// Assertion helpers for the box lock table checker.
// Each macro samples on clk and is disabled during rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge.
`define PBLT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define PBLT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/pblt_pkg.sv -----
// ----------------------------------------------------------------------------
// pblt_pkg
// Types, codes and default sizes shared by the box lock table modules.
// ----------------------------------------------------------------------------
`default_nettype none

package pblt_pkg;

  localparam int LockEntriesDef = 64;
  localparam int RegionsDef     = 8;
  localparam int TxnEntriesDef  = 16;
  localparam int DW             = 32;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_CONFLICT = 2'd1;
  localparam logic [1:0] ST_CAPACITY = 2'd2;

  // sorted set operations
  localparam logic [1:0] SET_NOP = 2'd0;
  localparam logic [1:0] SET_ADD = 2'd1;
  localparam logic [1:0] SET_RM  = 2'd2;

  typedef struct packed {
    logic [DW-1:0] slo;
    logic [DW-1:0] shi;
    logic [DW-1:0] plo;
    logic [DW-1:0] phi;
    logic [DW-1:0] olo;
    logic [DW-1:0] ohi;
    logic          excl;
  } region_t;

  typedef struct packed {
    logic [DW-1:0] slo;
    logic [DW-1:0] shi;
    logic [DW-1:0] plo;
    logic [DW-1:0] phi;
    logic [DW-1:0] olo;
    logic [DW-1:0] ohi;
    logic [DW-1:0] owner;
    logic          excl;
  } held_t;

  typedef struct packed {
    logic       take_region;
    logic       take_finish;
    logic       pend_clear;
    logic       e_clear;
    logic       e_inc;
    logic       r_clear;
    logic       r_inc;
    logic       entry_read;
    logic       append;
    logic       act_add;
    logic       com_add;
    logic       retire;
    logic       drain;
    logic       held_clear;
    logic       k_clear;
    logic       pack_write;
    logic       res_load;
    logic [1:0] res_status;
  } dp_cmd_t;

  typedef struct packed {
    logic overflow;
    logic held_empty;
    logic e_last;
    logic r_last;
    logic conflict;
    logic cap_fail;
    logic act_empty;
    logic is_oldest;
    logic com_add_ok;
    logic drain_more;
    logic res_busy;
  } dp_stat_t;

endpackage

`default_nettype wire

// ----- sv/predicate_box_lock_table_top.sv -----
// ----------------------------------------------------------------------------
// predicate_box_lock_table_top
// Lock table of subject/predicate/object boxes with transaction tracking.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_ready): func=0 transfers one region of a lock
//    request; the request closes at last_region. func=1 reports a finished
//    transaction in txn_id. Only one item is in work at a time.
//  - Output channel (out_valid/out_ready): one status per closing region and
//    per finish event; none for other regions. 0 ok, 1 conflict, 2 capacity.
//  - Non-last regions are taken without leaving the idle state. The time a
//    closing region takes is set by the single read port of the lock table
//    RAM: each stored lock is read once and then compared with one pending
//    region per cycle, and a grant writes one lock per cycle. A finish that
//    retires the oldest drains committed ids and then compacts the lock
//    table.
//  - The result sits in an output register; while the receiver stalls the
//    block keeps taking items and only holds when a second result is ready.
//  - Reset (rst, synchronous) empties the lock table, the pending request and
//    both transaction sets; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module predicate_box_lock_table_top import pblt_pkg::*; #(
  parameter int LockEntries = LockEntriesDef,
  parameter int Regions     = RegionsDef,
  parameter int TxnEntries  = TxnEntriesDef
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output      logic          in_ready,
  input  wire logic          func,
  input  wire logic [DW-1:0] txn_id,
  input  wire logic [DW-1:0] subject_low,
  input  wire logic [DW-1:0] subject_high,
  input  wire logic [DW-1:0] predicate_low,
  input  wire logic [DW-1:0] predicate_high,
  input  wire logic [DW-1:0] object_low,
  input  wire logic [DW-1:0] object_high,
  input  wire logic          exclusive,
  input  wire logic          last_region,
  output      logic          out_valid,
  input  wire logic          out_ready,
  output      logic [1:0]    status
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer
  pblt_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .func       (func),
    .last_region(last_region),
    .cmd        (cmd),
    .stat       (stat)
  );

  // storage and compare logic
  pblt_dp #(
    .LockEntries(LockEntries),
    .Regions    (Regions),
    .TxnEntries (TxnEntries)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .txn_id        (txn_id),
    .subject_low   (subject_low),
    .subject_high  (subject_high),
    .predicate_low (predicate_low),
    .predicate_high(predicate_high),
    .object_low    (object_low),
    .object_high   (object_high),
    .exclusive     (exclusive),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status)
  );

endmodule

`default_nettype wire

// ----- sv/pblt_ram.sv -----
// ----------------------------------------------------------------------------
// pblt_ram
// Generic single write port RAM with registered, enabled read.
// ----------------------------------------------------------------------------
`default_nettype none

module pblt_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output      logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- sv/pblt_set.sv -----
// ----------------------------------------------------------------------------
// pblt_set
// Sorted set of transaction ids, no duplicates; one add or remove per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pblt_set import pblt_pkg::*; #(
  parameter int Entries = TxnEntriesDef
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic [1:0]    op,
  input  wire logic [DW-1:0] val,
  output      logic          has_val,
  output      logic          full,
  output      logic          empty,
  output      logic [DW-1:0] first,
  output      logic [DW-1:0] nxt_first,
  output      logic          nxt_nz
);

  localparam int CW = $clog2(Entries + 1);

  logic [DW-1:0] ids      [Entries];
  logic [DW-1:0] ids_next [Entries];
  logic [DW-1:0] ids_dn   [Entries];
  logic [DW-1:0] ids_up   [Entries];
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [Entries-1:0] eqv;
  logic [Entries-1:0] lt;
  logic [Entries-1:0] lt_prev;
  logic [Entries-1:0] pre;

  always_comb begin
    for (int j = 0; j < Entries; j++) begin
      eqv[j] = (count > CW'(j)) && (ids[j] == val);
      lt[j]  = (count > CW'(j)) && (ids[j] < val);
      ids_up[j] = (j == Entries - 1) ? ids[j] : ids[(j + 1) % Entries];
      ids_dn[j] = (j == 0) ? val : ids[(j + Entries - 1) % Entries];
      lt_prev[j] = (j == 0) ? 1'b1 : lt[(j + Entries - 1) % Entries];
    end
    pre[0] = eqv[0];
    for (int j = 1; j < Entries; j++) begin
      pre[j] = pre[j-1] | eqv[j];
    end
  end

  assign has_val = |eqv;
  assign full    = (count == CW'(Entries));
  assign empty   = (count == '0);
  assign first   = ids[0];

  always_comb begin
    ids_next   = ids;
    count_next = count;
    case (op)
      SET_ADD: begin
        if (!has_val && !full) begin
          for (int j = 0; j < Entries; j++) begin
            ids_next[j] = lt[j] ? ids[j] : (lt_prev[j] ? val : ids_dn[j]);
          end
          count_next = count + CW'(1);
        end
      end
      SET_RM: begin
        if (has_val) begin
          for (int j = 0; j < Entries; j++) begin
            ids_next[j] = pre[j] ? ids_up[j] : ids[j];
          end
          count_next = count - CW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  assign nxt_first = ids_next[0];
  assign nxt_nz    = (count_next != '0);

  always_ff @(posedge clk) begin
    ids <= ids_next;
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

endmodule

`default_nettype wire

// ----- sv/pblt_dp.sv -----
// ----------------------------------------------------------------------------
// pblt_dp
// Datapath: pending request, lock table RAM, transaction sets, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pblt_dp import pblt_pkg::*; #(
  parameter int LockEntries = LockEntriesDef,
  parameter int Regions     = RegionsDef,
  parameter int TxnEntries  = TxnEntriesDef
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire dp_cmd_t       cmd,
  output      dp_stat_t      stat,
  input  wire logic [DW-1:0] txn_id,
  input  wire logic [DW-1:0] subject_low,
  input  wire logic [DW-1:0] subject_high,
  input  wire logic [DW-1:0] predicate_low,
  input  wire logic [DW-1:0] predicate_high,
  input  wire logic [DW-1:0] object_low,
  input  wire logic [DW-1:0] object_high,
  input  wire logic          exclusive,
  output      logic          out_valid,
  input  wire logic          out_ready,
  output      logic [1:0]    status
);

  localparam int AW = $clog2(LockEntries);
  localparam int CW = $clog2(LockEntries + 1);
  localparam int RW = (Regions > 1) ? $clog2(Regions) : 1;
  localparam int PW = $clog2(Regions + 2);

  region_t       pend [Regions];
  logic [PW-1:0] pend_count;
  logic [DW-1:0] pend_owner;
  logic [DW-1:0] fin_txn;
  logic [CW-1:0] held_count;
  logic [CW-1:0] e;
  logic [CW-1:0] k;
  logic [RW-1:0] r;
  logic [DW-1:0] oldest;

  region_t cur;
  held_t   ent;
  held_t   wentry;
  logic    keep;
  logic    hits;

  logic [1:0]    act_op;
  logic [DW-1:0] act_val;
  logic          act_has, act_full, act_empty, act_nxt_nz;
  logic [DW-1:0] act_first, act_nxt_first;
  logic [1:0]    com_op;
  logic [DW-1:0] com_val;
  logic          com_has, com_full, com_empty;
  logic [DW-1:0] com_first;

  assign cur  = pend[r];
  assign keep = (ent.owner >= oldest);

  // pending region capture
  always_ff @(posedge clk) begin
    if (cmd.take_region) begin
      if (pend_count == '0) begin
        pend_owner <= txn_id;
      end
      if (pend_count < PW'(Regions)) begin
        pend[pend_count[RW-1:0]] <= '{subject_low, subject_high, predicate_low,
                                      predicate_high, object_low, object_high, exclusive};
      end
    end
    if (cmd.take_finish) begin
      fin_txn <= txn_id;
    end
    if (rst) begin
      pend_count <= '0;
    end else if (cmd.pend_clear) begin
      pend_count <= '0;
    end else if (cmd.take_region) begin
      pend_count <= (pend_count < PW'(Regions)) ? pend_count + PW'(1) : PW'(Regions + 1);
    end
  end

  // counters, held count and oldest mark
  always_ff @(posedge clk) begin
    if (cmd.e_clear) begin
      e <= '0;
    end else if (cmd.e_inc) begin
      e <= e + CW'(1);
    end
    if (cmd.r_clear) begin
      r <= '0;
    end else if (cmd.r_inc) begin
      r <= r + RW'(1);
    end
    if (cmd.k_clear) begin
      k <= '0;
    end else if (cmd.pack_write && keep) begin
      k <= k + CW'(1);
    end
    if (cmd.retire) begin
      oldest <= act_nxt_nz ? act_nxt_first : '0;
    end else if (cmd.drain && act_nxt_nz) begin
      oldest <= act_nxt_first;
    end
    if (rst) begin
      held_count <= '0;
    end else if (cmd.held_clear) begin
      held_count <= '0;
    end else if (cmd.append) begin
      held_count <= held_count + CW'(1);
    end else if (cmd.pack_write && stat.e_last) begin
      held_count <= k + CW'(keep);
    end
  end

  // lock table
  assign wentry = cmd.append ? '{cur.slo, cur.shi, cur.plo, cur.phi, cur.olo, cur.ohi,
                                 pend_owner, cur.excl} : ent;

  pblt_ram #(
    .Width($bits(held_t)),
    .Depth(LockEntries)
  ) u_ram (
    .clk  (clk),
    .we   (cmd.append || (cmd.pack_write && keep)),
    .waddr(cmd.append ? held_count[AW-1:0] : k[AW-1:0]),
    .wdata(wentry),
    .re   (cmd.entry_read),
    .raddr(e[AW-1:0]),
    .rdata(ent)
  );

  // transaction sets
  always_comb begin
    act_op  = SET_NOP;
    act_val = pend_owner;
    if (cmd.act_add) begin
      act_op = SET_ADD;
    end else if (cmd.retire) begin
      act_op  = SET_RM;
      act_val = act_first;
    end else if (cmd.drain) begin
      act_op  = SET_RM;
      act_val = com_first;
    end
    com_op  = SET_NOP;
    com_val = ent.owner;
    if (cmd.com_add) begin
      com_op  = SET_ADD;
      com_val = fin_txn;
    end else if (cmd.drain) begin
      com_op  = SET_RM;
      com_val = com_first;
    end
  end

  pblt_set #(.Entries(TxnEntries)) u_act (
    .clk(clk), .rst(rst), .op(act_op), .val(act_val),
    .has_val(act_has), .full(act_full), .empty(act_empty), .first(act_first),
    .nxt_first(act_nxt_first), .nxt_nz(act_nxt_nz)
  );

  pblt_set #(.Entries(TxnEntries)) u_com (
    .clk(clk), .rst(rst), .op(com_op), .val(com_val),
    .has_val(com_has), .full(com_full), .empty(com_empty), .first(com_first),
    .nxt_first(), .nxt_nz()
  );

  // conflict test of one stored lock against one pending region
  assign hits = (ent.slo <= cur.shi) && (ent.shi >= cur.slo) &&
                (ent.plo <= cur.phi) && (ent.phi >= cur.plo) &&
                (ent.olo <= cur.ohi) && (ent.ohi >= cur.olo);

  always_comb begin
    stat.overflow   = (pend_count > PW'(Regions));
    stat.held_empty = (held_count == '0);
    stat.e_last     = (e + CW'(1) == held_count);
    stat.r_last     = (PW'(r) + PW'(1) == pend_count);
    stat.conflict   = hits && (ent.owner != pend_owner) && (cur.excl || ent.excl) && !com_has;
    stat.cap_fail   = ({1'b0, held_count} + (CW+1)'(pend_count) > (CW+1)'(LockEntries)) ||
                      (!act_has && act_full);
    stat.act_empty  = act_empty;
    stat.is_oldest  = (fin_txn == act_first);
    stat.com_add_ok = com_has || !com_full;
    stat.drain_more = !com_empty && (com_first <= oldest);
    stat.res_busy   = out_valid && !out_ready;
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      status <= cmd.res_status;
    end
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// ----- sv/pblt_ctrl.sv -----
// ----------------------------------------------------------------------------
// pblt_ctrl
// Sequencer: request check, append, finish/retire, drain and table compaction.
// ----------------------------------------------------------------------------
`default_nettype none

module pblt_ctrl import pblt_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output      logic     in_ready,
  input  wire logic     func,
  input  wire logic     last_region,
  output      dp_cmd_t  cmd,
  input  wire dp_stat_t stat
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_CHECK    = 4'd1;
  localparam logic [3:0] S_SCAN_RD  = 4'd2;
  localparam logic [3:0] S_SCAN_CMP = 4'd3;
  localparam logic [3:0] S_CAP      = 4'd4;
  localparam logic [3:0] S_APPEND   = 4'd5;
  localparam logic [3:0] S_FIN      = 4'd6;
  localparam logic [3:0] S_DRAIN    = 4'd7;
  localparam logic [3:0] S_PACK_RD  = 4'd8;
  localparam logic [3:0] S_PACK_WR  = 4'd9;
  localparam logic [3:0] S_RESULT   = 4'd10;

  logic [3:0] state, state_next;
  logic [1:0] res_code, res_code_next;
  logic       accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd           = '0;
    state_next    = state;
    res_code_next = res_code;
    cmd.res_status = res_code;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (func) begin
            cmd.take_finish = 1'b1;
            state_next = S_FIN;
          end else begin
            cmd.take_region = 1'b1;
            if (last_region) begin
              state_next = S_CHECK;
            end
          end
        end
      end
      S_CHECK: begin
        cmd.e_clear = 1'b1;
        if (stat.overflow) begin
          cmd.pend_clear = 1'b1;
          res_code_next  = ST_CAPACITY;
          state_next     = S_RESULT;
        end else if (stat.held_empty) begin
          state_next = S_CAP;
        end else begin
          state_next = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        cmd.entry_read = 1'b1;
        cmd.r_clear    = 1'b1;
        state_next     = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        if (stat.conflict) begin
          cmd.pend_clear = 1'b1;
          res_code_next  = ST_CONFLICT;
          state_next     = S_RESULT;
        end else if (stat.r_last) begin
          if (stat.e_last) begin
            state_next = S_CAP;
          end else begin
            cmd.e_inc  = 1'b1;
            state_next = S_SCAN_RD;
          end
        end else begin
          cmd.r_inc = 1'b1;
        end
      end
      S_CAP: begin
        cmd.r_clear = 1'b1;
        if (stat.cap_fail) begin
          cmd.pend_clear = 1'b1;
          res_code_next  = ST_CAPACITY;
          state_next     = S_RESULT;
        end else begin
          state_next = S_APPEND;
        end
      end
      S_APPEND: begin
        cmd.append = 1'b1;
        cmd.r_inc  = 1'b1;
        if (stat.r_last) begin
          cmd.act_add    = 1'b1;
          cmd.pend_clear = 1'b1;
          res_code_next  = ST_OK;
          state_next     = S_RESULT;
        end
      end
      S_FIN: begin
        if (stat.act_empty) begin
          res_code_next = ST_OK;
          state_next    = S_RESULT;
        end else if (!stat.is_oldest) begin
          cmd.com_add   = 1'b1;
          res_code_next = stat.com_add_ok ? ST_OK : ST_CAPACITY;
          state_next    = S_RESULT;
        end else begin
          cmd.retire = 1'b1;
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        res_code_next = ST_OK;
        if (stat.drain_more) begin
          cmd.drain = 1'b1;
        end else if (stat.act_empty) begin
          cmd.held_clear = 1'b1;
          state_next     = S_RESULT;
        end else begin
          cmd.e_clear = 1'b1;
          cmd.k_clear = 1'b1;
          state_next  = stat.held_empty ? S_RESULT : S_PACK_RD;
        end
      end
      S_PACK_RD: begin
        cmd.entry_read = 1'b1;
        state_next     = S_PACK_WR;
      end
      S_PACK_WR: begin
        cmd.pack_write = 1'b1;
        cmd.e_inc      = 1'b1;
        state_next     = stat.e_last ? S_RESULT : S_PACK_RD;
      end
      S_RESULT: begin
        if (!stat.res_busy) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    res_code <= res_code_next;
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ----- sv/pblt_checker.sv -----
// ----------------------------------------------------------------------------
// pblt_checker
// Port level checks of the box lock table, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module pblt_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       func,
  input wire logic       last_region,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [1:0] status
);

  `PBLT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status), "stalled result changed")
  `PBLT_ASSERT_IMPL(a_status_code, out_valid, status != 2'd3, "undefined status code")
  `PBLT_ASSERT_NEXT(a_busy_after_close, in_valid && in_ready && (func || last_region), !in_ready, "input taken during request work")

endmodule

bind predicate_box_lock_table_top pblt_checker u_pblt_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .func       (func),
  .last_region(last_region),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .status     (status)
);

`default_nettype wire
